/* src/lal_pkg.sv */
// ----------------------------------------------------------------------------
// lal_pkg
// Shared types, constants and elaboration-time tables for the log-average
// luminance block.
// ----------------------------------------------------------------------------
package lal_pkg;

   localparam int MAX_PIXELS_DEF    = 4194304;
   localparam int LOG_FRAC_BITS_DEF = 16;
   localparam int LFB_MAX           = 24;
   localparam int CNT_W             = 27;
   localparam int SUM_W             = 48;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [15:0] W_RED   = 16'd13933;
   localparam logic [15:0] W_GREEN = 16'd46871;
   localparam logic [15:0] W_BLUE  = 16'd4732;

   typedef struct packed {
      logic [31:0] red_value;
      logic [31:0] green_value;
      logic [31:0] blue_value;
      logic        last_pixel;
   } lal_req_type;

   typedef struct packed {
      logic [31:0] mean_luminance;
      logic [22:0] pixels_counted;
      logic        count_overflow;
   } lal_rsp_type;

   typedef struct packed {
      logic [31:0]      luminance;
      logic             counted;
      logic             last;
      logic [CNT_W-1:0] count;
      logic             overflow;
   } lal_entry_type;

   typedef logic [31:0] lal_root_tab_type [0:LFB_MAX];

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic lal_root_tab_type build_roots();
      lal_root_tab_type t;
      logic [63:0]      v;
      v    = 64'h8000_0000;
      t[0] = 32'h8000_0000;
      for (int k = 1; k <= LFB_MAX; k++) begin
         v    = isqrt64(v << 30);
         t[k] = v[31:0];
      end
      return t;
   endfunction

endpackage

/* src/lal_front.sv */
// ----------------------------------------------------------------------------
// lal_front
// Accepts pixels, forms luminance and classifies each pixel as counted or
// dropped against the pixel limit.
// ----------------------------------------------------------------------------
module lal_front #(
   parameter int MAX_PIXELS = lal_pkg::MAX_PIXELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lal_pkg::lal_req_type   req_payload,
   input  logic                   q_full,
   output logic                   q_push,
   output lal_pkg::lal_entry_type q_entry
);
   import lal_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             accept;
   logic             counted;
   logic [CNT_W-1:0] cnt_next;
   logic             ovf_next;
   logic [49:0]      lum_sum;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   assign lum_sum = 50'(req_payload.red_value)   * 50'(W_RED)
                  + 50'(req_payload.green_value) * 50'(W_GREEN)
                  + 50'(req_payload.blue_value)  * 50'(W_BLUE);

   assign counted  = (cnt_ff != CNT_W'(MAX_PIXELS));
   assign cnt_next = counted ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign ovf_next = ovf_ff | ~counted;

   assign q_push            = accept;
   assign q_entry.luminance = lum_sum[47:16];
   assign q_entry.counted   = counted;
   assign q_entry.last      = req_payload.last_pixel;
   assign q_entry.count     = cnt_next;
   assign q_entry.overflow  = ovf_next;

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         cnt_in = req_payload.last_pixel ? '0 : cnt_next;
         ovf_in = req_payload.last_pixel ? 1'b0 : ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

/* src/lal_queue.sv */
// ----------------------------------------------------------------------------
// lal_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module lal_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lal_pkg::lal_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output lal_pkg::lal_entry_type head
);
   import lal_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   lal_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (fill_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_in   = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in   = do_pop  ? rd_ff + PTR_W'(1) : rd_ff;
      fill_in = fill_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* src/lal_back.sv */
// ----------------------------------------------------------------------------
// lal_back
// Sequencer that takes log2 of each counted pixel, keeps the running sum and
// on the last pixel divides, raises the power of two and issues the result.
// ----------------------------------------------------------------------------
module lal_back #(
   parameter int LOG_FRAC_BITS = lal_pkg::LOG_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  lal_pkg::lal_entry_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lal_pkg::lal_rsp_type   rsp_payload
);
   import lal_pkg::*;

   localparam lal_root_tab_type ROOT_TAB = build_roots();

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOG  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_MEAN = 3'd4;
   localparam logic [2:0] ST_EXP  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [4:0]              step_ff, step_in;
   logic [5:0]              dstep_ff, dstep_in;
   logic                    last_ff, last_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [31:0]             m_ff, m_in;
   logic signed [6:0]       ipart_ff, ipart_in;
   logic [LFB_MAX-1:0]      frac_ff, frac_in;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        dvd_ff, dvd_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic signed [SUM_W-1:0] ip_ff, ip_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lal_rsp_type             rsp_ff, rsp_in;

   logic [32:0]             v;
   logic [5:0]              msb;
   logic [32:0]             norm;
   logic [61:0]             sq;
   logic [31:0]             sq_top;
   logic signed [SUM_W:0]   logv;
   logic signed [SUM_W:0]   acc;
   logic [CNT_W:0]          trial;
   logic signed [SUM_W-1:0] mean;
   logic [63:0]             ep;
   logic signed [7:0]       shamt;
   logic [33:0]             up;
   logic [31:0]             result;
   logic                    slot_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign slot_free   = ~rsp_valid_ff | ~rsp_stall;
   assign q_pop       = (state_ff == ST_IDLE) & q_valid;

   always_comb begin
      v   = 33'(q_head.luminance) + 33'd1;
      msb = '0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) begin
            msb = 6'(i);
         end
      end
      norm = (msb <= 6'd30) ? (v << (6'd30 - msb)) : (v >> (msb - 6'd30));
   end

   assign sq     = 62'(m_ff[30:0]) * 62'(m_ff[30:0]);
   assign sq_top = sq[61:30];

   assign logv = ($signed(49'(ipart_ff)) <<< LOG_FRAC_BITS) + $signed({25'b0, frac_ff});
   assign acc  = $signed({sum_ff[SUM_W-1], sum_ff}) + logv;

   assign trial = {rem_ff, dvd_ff[SUM_W-1]};

   assign mean = (cnt_ff == '0) ? '0 : (neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff));

   assign ep = 64'(m_ff) * 64'(ROOT_TAB[step_ff]);

   always_comb begin
      shamt  = $signed(ip_ff[7:0]) - 8'sd14;
      up     = 34'(m_ff) << shamt[1:0];
      if (ip_ff > 48'sd16) begin
         result = 32'hFFFF_FFFF;
      end else if (ip_ff < -48'sd49) begin
         result = '0;
      end else if (shamt >= 8'sd0) begin
         result = (up[33:32] != 2'b00) ? 32'hFFFF_FFFF : up[31:0];
      end else begin
         result = m_ff >> 6'(-shamt);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      dstep_in     = dstep_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      m_in         = m_ff;
      ipart_in     = ipart_ff;
      frac_in      = frac_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      ip_in        = ip_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               last_in  = q_head.last;
               cnt_in   = q_head.count;
               ovf_in   = q_head.overflow;
               m_in     = {1'b0, norm[30:0]};
               ipart_in = 7'(msb) - 7'sd16;
               frac_in  = '0;
               step_in  = '0;
               neg_in   = sum_ff[SUM_W-1];
               dvd_in   = sum_ff[SUM_W-1] ? 48'(-sum_ff) : 48'(sum_ff);
               rem_in   = '0;
               dstep_in = '0;
               if (q_head.counted) begin
                  state_in = ST_LOG;
               end else if (q_head.last) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_LOG: begin
            frac_in = {frac_ff[LFB_MAX-2:0], sq_top[31]};
            m_in    = sq_top[31] ? {1'b0, sq_top[31:1]} : {1'b0, sq_top[30:0]};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(LOG_FRAC_BITS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (acc[SUM_W] != acc[SUM_W-1]) begin
               sum_in = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               sum_in = acc[SUM_W-1:0];
            end
            neg_in   = sum_in[SUM_W-1];
            dvd_in   = sum_in[SUM_W-1] ? 48'(-sum_in) : 48'(sum_in);
            state_in = last_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (trial >= {1'b0, cnt_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, cnt_ff});
               dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CNT_W-1:0];
               dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
            end
            dstep_in = dstep_ff + 6'd1;
            if (dstep_ff == 6'(SUM_W - 1)) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            ip_in    = mean >>> LOG_FRAC_BITS;
            frac_in  = LFB_MAX'(mean[LFB_MAX-1:0] << (LFB_MAX - LOG_FRAC_BITS));
            m_in     = 32'h4000_0000;
            step_in  = 5'd1;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            if (frac_ff[LFB_MAX-1]) begin
               m_in = ep[61:30];
            end
            frac_in = {frac_ff[LFB_MAX-2:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(LOG_FRAC_BITS)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_in.mean_luminance = result;
               rsp_in.pixels_counted = cnt_ff[22:0];
               rsp_in.count_overflow = ovf_ff;
               rsp_valid_in          = 1'b1;
               sum_in                = '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      dstep_ff <= dstep_in;
      last_ff  <= last_in;
      cnt_ff   <= cnt_in;
      ovf_ff   <= ovf_in;
      m_ff     <= m_in;
      ipart_ff <= ipart_in;
      frac_ff  <= frac_in;
      neg_ff   <= neg_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      ip_ff    <= ip_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/log_average_luminance.sv */
// ----------------------------------------------------------------------------
// log_average_luminance
// Geometric-mean luminance of a frame of HDR pixels via a base-2 log sum.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  lal_req_type (one pixel)
//   rsp      out        rsp_valid/rsp_stall  lal_rsp_type (one per frame)
//
// A counted pixel occupies the back sequencer for one squaring multiplier step
// per fraction bit plus an accumulate step; a dropped pixel only passes idle.
// A last pixel adds a bit-serial divide of the 48-bit sum, then one exp2 step per fraction bit.
// The front accepts a pixel per cycle while the four-entry queue has room.
// Reset is synchronous and clears the sum, counts and all handshake state.
// ----------------------------------------------------------------------------
module log_average_luminance #(
   parameter int MAX_PIXELS    = lal_pkg::MAX_PIXELS_DEF,
   parameter int LOG_FRAC_BITS = lal_pkg::LOG_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lal_pkg::lal_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lal_pkg::lal_rsp_type rsp_payload
);
   import lal_pkg::*;

   logic          q_full;
   logic          q_push;
   lal_entry_type q_entry;
   logic          q_pop;
   logic          q_valid;
   lal_entry_type q_head;

   lal_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   lal_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   lal_back #(
      .LOG_FRAC_BITS(LOG_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

/* src/lal_checker.sv */
// ----------------------------------------------------------------------------
// lal_checker
// Port-level checks on the result channel of the luminance block.
// ----------------------------------------------------------------------------
module lal_checker #(
   parameter int MAX_PIXELS = lal_pkg::MAX_PIXELS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lal_pkg::lal_rsp_type rsp_payload
);
   import lal_pkg::*;

   localparam logic [22:0] MAX_LOW = 23'(MAX_PIXELS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.count_overflow |-> rsp_payload.pixels_counted == MAX_LOW)
      else $error("overflow reported below the pixel limit");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (MAX_PIXELS < 8388608) && rsp_valid |->
         rsp_payload.pixels_counted <= MAX_LOW && rsp_payload.pixels_counted != 23'd0)
      else $error("pixel count out of range");

endmodule

bind log_average_luminance lal_checker #(
   .MAX_PIXELS(MAX_PIXELS)
) u_lal_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);
